@@ design/morse_character_keyer_core_macros.svh @@
// Assertion macros for the keyer core.
`ifndef MORSE_CHARACTER_KEYER_CORE_MACROS_SVH
`define MORSE_CHARACTER_KEYER_CORE_MACROS_SVH

`ifndef SYNTH
`define MCK_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyer core assertion failed");
`define MCK_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyer core assertion failed");
`else
`define MCK_ASSERT_SAME(lbl, ante, cons)
`define MCK_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ design/mck_pkg.sv @@
package mck_pkg;

    localparam int DURATION_BITS_DEF = 24;

    localparam int DIV_W     = 32;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int DSR_W     = 7;
    localparam int UNIT_W    = 21;
    localparam int CORR_W    = 16;

    localparam logic [DIV_W-1:0] UNIT_NUM   = 32'd1200000;
    localparam logic [5:0]       CORR_SCALE = 6'd50;

    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_FIRST = 8'd33;
    localparam logic [7:0] CHAR_LAST  = 8'd126;
    localparam logic [7:0] PAT_EMPTY  = 8'd1;

    localparam logic [6:0] SPEED_MIN  = 7'd1;
    localparam logic [6:0] WEIGHT_MIN = 7'd17;
    localparam logic [6:0] WEIGHT_OFS = 7'd16;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORR   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PTT    = 4'd3;

    localparam logic [6:0] SPEED_RST  = 7'd20;
    localparam logic [6:0] WEIGHT_RST = 7'd48;

    typedef struct packed {
        logic [6:0] speed_wpm;
        logic [6:0] weight_x16;
        logic [9:0] corr_us;
        logic       ptt_on;
    } cfg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

    // reverse-binary patterns for codes 33..126; top set bit is the stop mark
    localparam logic [7:0] MORSE_ROM [94] = '{
        8'h75, 8'h52, 8'h01, 8'h01, 8'h68, 8'h1A, 8'h5E, 8'h2D, 8'h6D, 8'h01,
        8'h2D, 8'h73, 8'h31, 8'h2A, 8'h29,
        8'h3F, 8'h3E, 8'h3C, 8'h38, 8'h30, 8'h20, 8'h21, 8'h23, 8'h27, 8'h2F,
        8'h47, 8'h55, 8'h22, 8'h31, 8'h2A, 8'h4C, 8'h56,
        8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B, 8'h10, 8'h04, 8'h1E,
        8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16, 8'h1B, 8'h0A, 8'h08, 8'h03,
        8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13,
        8'h01, 8'h40, 8'h01, 8'h01, 8'h6C, 8'h5E,
        8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B, 8'h10, 8'h04, 8'h1E,
        8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16, 8'h1B, 8'h0A, 8'h08, 8'h03,
        8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13,
        8'h70, 8'h01, 8'h28, 8'h01
    };

    function automatic logic [7:0] morse_lookup(input logic [7:0] code);
        logic [6:0] idx;
        idx = 7'(code - CHAR_FIRST);
        if (code >= CHAR_FIRST && code <= CHAR_LAST)
            return MORSE_ROM[idx];
        else
            return PAT_EMPTY;
    endfunction

endpackage

@@ design/mck_div.sv @@
module mck_div
    import mck_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DIV_W-1:0]     dvd_reg;
    logic [DSR_W-1:0]     dsr_reg;
    logic [DSR_W-1:0]     rem_reg;
    logic [DSR_W-1:0]     rem_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DSR_W:0]       trial;
    logic                 fits;

    // restoring division, one quotient bit per cycle
    assign trial    = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign rem_next = fits ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

@@ design/mck_seq.sv @@
module mck_seq
    import mck_pkg::*;
#(
    parameter  int DURATION_BITS = DURATION_BITS_DEF,
    localparam int TDATA_W       = ((DURATION_BITS + 2 + 7) / 8) * 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,
    output logic               m_tlast,
    output div_req_t           div_req,
    input  div_rsp_t           div_rsp
);

    localparam int DUR_EXT_W = DIV_W + 1;
    localparam logic [DUR_EXT_W-1:0] DUR_TOP =
        DUR_EXT_W'((64'd1 << DURATION_BITS) - 64'd1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_UNIT = 5'b00010,
        S_DIT  = 5'b00100,
        S_DASH = 5'b01000,
        S_SEND = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [7:0]         pat_reg;
    logic               space_reg;
    logic               phase_reg;
    logic               last_space_reg;
    logic [UNIT_W-1:0]  unit_reg;
    logic [DIV_W-1:0]   dit_reg;
    logic [DIV_W-1:0]   dash_reg;
    logic [DIV_W-1:0]   prod_reg;
    logic [DIV_W-1:0]   gap_reg;
    logic               m_valid_reg;
    logic [TDATA_W-1:0] m_data_reg;
    logic               m_last_reg;

    logic [6:0]          spd;
    logic [6:0]          xw;
    logic [6:0]          xd;
    logic [UNIT_W+7:0]   mul;
    logic [CORR_W-1:0]   corr_scaled;
    logic [DIV_W-1:0]    unit32;
    logic [DIV_W-1:0]    comp;
    logic [DIV_W-1:0]    unit3;
    logic [DIV_W-1:0]    gap_next;
    logic                out_free;
    logic                emit;
    logic                seg_key;
    logic                seg_ptt;
    logic [DIV_W-1:0]    seg_dur;
    logic                seg_last;
    logic [DURATION_BITS-1:0] dur_sat;

    assign spd = (cfg.speed_wpm == 7'd0) ? SPEED_MIN : cfg.speed_wpm;
    assign xw  = (cfg.weight_x16 < WEIGHT_MIN) ? WEIGHT_MIN : cfg.weight_x16;
    assign xd  = xw - WEIGHT_OFS;

    assign mul         = (UNIT_W+8)'(div_rsp.quotient[UNIT_W-1:0]) *
                         (UNIT_W+8)'({xw, 1'b0});
    assign corr_scaled = CORR_W'(cfg.corr_us) * CORR_W'(CORR_SCALE);
    assign unit32      = DIV_W'(unit_reg);
    assign comp        = (unit32 > DIV_W'(corr_scaled)) ?
                         unit32 - DIV_W'(corr_scaled) : unit32;
    assign unit3       = (unit32 << 1) + unit32;
    assign gap_next    = (last_space_reg ? (unit3 << 1) : unit3) + comp;

    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = (state_reg == S_SEND) && out_free;

    always_comb
    begin
        div_req    = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = UNIT_NUM;
                    div_req.divisor  = spd;
                    state_next       = S_UNIT;
                end
            end
            S_UNIT:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'({div_rsp.quotient[UNIT_W-1:0], 5'b0});
                    div_req.divisor  = xd;
                    state_next       = S_DIT;
                end
            end
            S_DIT:
            begin
                if (div_rsp.done)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = prod_reg;
                    div_req.divisor  = xd;
                    state_next       = S_DASH;
                end
            end
            S_DASH:
            begin
                if (div_rsp.done)
                    state_next = S_SEND;
            end
            S_SEND:
            begin
                if (emit && seg_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        seg_key  = 1'b0;
        seg_ptt  = 1'b0;
        seg_last = 1'b1;
        seg_dur  = unit32 << 1;
        if (space_reg)
        begin
            seg_dur = gap_reg;
        end
        else if (pat_reg > PAT_EMPTY)
        begin
            seg_ptt  = cfg.ptt_on;
            seg_last = 1'b0;
            if (!phase_reg)
            begin
                seg_key = 1'b1;
                seg_dur = pat_reg[0] ? dash_reg : dit_reg;
            end
            else
            begin
                seg_dur = unit32;
            end
        end
    end

    assign dur_sat = ({1'b0, seg_dur} > DUR_TOP) ? DUR_TOP[DURATION_BITS-1:0]
                                                  : seg_dur[DURATION_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            m_valid_reg    <= 1'b0;
            last_space_reg <= 1'b0;
            phase_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && s_tvalid)
                phase_reg <= 1'b0;
            if (emit)
            begin
                m_valid_reg <= 1'b1;
                if (!space_reg && pat_reg > PAT_EMPTY)
                    phase_reg <= !phase_reg;
                if (seg_last)
                    last_space_reg <= space_reg;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            pat_reg   <= morse_lookup(s_tdata);
            space_reg <= (s_tdata == CHAR_SPACE);
        end
        if (state_reg == S_UNIT && div_rsp.done)
        begin
            unit_reg <= div_rsp.quotient[UNIT_W-1:0];
            prod_reg <= DIV_W'(mul);
        end
        if (state_reg == S_DIT && div_rsp.done)
            dit_reg <= div_rsp.quotient;
        if (state_reg == S_DASH && div_rsp.done)
        begin
            dash_reg <= div_rsp.quotient;
            gap_reg  <= gap_next;
        end
        if (emit)
        begin
            m_data_reg <= TDATA_W'({dur_sat, seg_ptt, seg_key});
            m_last_reg <= seg_last;
            if (!space_reg && pat_reg > PAT_EMPTY && phase_reg)
                pat_reg <= pat_reg >> 1;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

@@ design/morse_character_keyer_core.sv @@
// Weighted Morse keyer core.
// Slave stream: one ASCII character per transfer in s_tdata; 32 is a word space.
// Master stream: one transfer per timed key segment. m_tdata carries the key
// level, PTT level and segment length in microseconds; m_tlast marks the last
// segment of a character (letter gap, or the word gap for a space).
// Config channel: cfg_index selects speed (0), weight (1), correction (2) or
// PTT enable (3); write only while no character is in flight. cfg_ready is
// always high and other indexes are ignored.
// Timing: each character runs three 32-step divisions on one shared divider
// (unit, dit, dash) before the first segment is sent; then one segment per cycle
// while m_tready is high. s_tready drops on accept and comes back once the last
// segment is loaded into the output register.
// A stalled receiver holds the current segment and stops the sequencer.
// Reset restores 20 wpm, weight 3, no correction, PTT off, no pending output.
module morse_character_keyer_core
    import mck_pkg::*;
#(
    parameter  int DURATION_BITS = DURATION_BITS_DEF,
    localparam int TDATA_W       = ((DURATION_BITS + 2 + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] char_code
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,   // [0] key_level, [1] ptt_level, duration_us, zeros
    output logic                  m_tlast,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    `include "morse_character_keyer_core_macros.svh"

    logic [6:0] speed_reg;
    logic [6:0] weight_reg;
    logic [9:0] corr_reg;
    logic       ptt_reg;
    cfg_t       cfg;
    div_req_t   div_req;
    div_rsp_t   div_rsp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= SPEED_RST;
            weight_reg <= WEIGHT_RST;
            corr_reg   <= '0;
            ptt_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_SPEED:  speed_reg  <= cfg_data[6:0];
                REG_WEIGHT: weight_reg <= cfg_data[6:0];
                REG_CORR:   corr_reg   <= cfg_data[9:0];
                REG_PTT:    ptt_reg    <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    assign cfg.speed_wpm  = speed_reg;
    assign cfg.weight_x16 = weight_reg;
    assign cfg.corr_us    = corr_reg;
    assign cfg.ptt_on     = ptt_reg;

    mck_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    mck_seq #(
        .DURATION_BITS (DURATION_BITS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .div_req  (div_req),
        .div_rsp  (div_rsp)
    );

    `MCK_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `MCK_ASSERT_SAME(a_key_not_last, m_tvalid && m_tdata[0], !m_tlast)
    `MCK_ASSERT_SAME(a_gap_quiet, m_tvalid && m_tlast, !m_tdata[0] && !m_tdata[1])

endmodule

@@ bench/morse_character_keyer_core_tb.sv @@
module morse_character_keyer_core_tb
    import mck_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TDATA_W    = ((DURATION_BITS_DEF + 2 + 7) / 8) * 8;
    localparam logic [63:0] DUR_MAX    = (64'd1 << DURATION_BITS_DEF) - 64'd1;
    localparam logic [63:0] UNIT_US    = 64'd1200000;
    localparam logic [63:0] CORR_STEP  = 64'd50;
    localparam logic [7:0]  SPACE_CODE = 8'd32;
    localparam logic [7:0]  FIRST_CODE = 8'd33;
    localparam logic [7:0]  LAST_CODE  = 8'd126;
    localparam logic [7:0]  NO_PATTERN = 8'd1;
    localparam logic [6:0]  LOW_WEIGHT = 7'd17;
    localparam logic [6:0]  WEIGHT_BASE = 7'd16;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd15;

    // reverse-binary element patterns, codes 33..126; top set bit is the stop mark
    localparam logic [7:0] ELEMENT_PATTERNS [94] = '{
        8'h75, 8'h52, 8'h01, 8'h01, 8'h68, 8'h1A, 8'h5E, 8'h2D, 8'h6D, 8'h01,
        8'h2D, 8'h73, 8'h31, 8'h2A, 8'h29,
        8'h3F, 8'h3E, 8'h3C, 8'h38, 8'h30, 8'h20, 8'h21, 8'h23, 8'h27, 8'h2F,
        8'h47, 8'h55, 8'h22, 8'h31, 8'h2A, 8'h4C, 8'h56,
        8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B, 8'h10, 8'h04, 8'h1E,
        8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16, 8'h1B, 8'h0A, 8'h08, 8'h03,
        8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13,
        8'h01, 8'h40, 8'h01, 8'h01, 8'h6C, 8'h5E,
        8'h06, 8'h11, 8'h15, 8'h09, 8'h02, 8'h14, 8'h0B, 8'h10, 8'h04, 8'h1E,
        8'h0D, 8'h12, 8'h07, 8'h05, 8'h0F, 8'h16, 8'h1B, 8'h0A, 8'h08, 8'h03,
        8'h0C, 8'h18, 8'h0E, 8'h19, 8'h1D, 8'h13,
        8'h70, 8'h01, 8'h28, 8'h01
    };

    typedef struct {
        logic                         key;
        logic                         ptt;
        logic [DURATION_BITS_DEF-1:0] dur;
        logic                         last;
    } key_segment_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [6:0] speed_reg = 7'd20;
    logic [6:0] weight_reg = 7'd48;
    logic [9:0] corr_reg = '0;
    logic       ptt_reg = 1'b0;
    logic       prev_was_space = 1'b0;

    key_segment_t segment_q [$];
    key_segment_t want_seg;
    int unsigned  mismatch_count = 0;
    int unsigned  burst_left = 0;

    morse_character_keyer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic void push_segment(input logic key, input logic ptt,
                                         input logic [63:0] dur, input logic last);
        key_segment_t seg;
        seg.key  = key;
        seg.ptt  = ptt;
        seg.dur  = (dur > DUR_MAX) ? DUR_MAX[DURATION_BITS_DEF-1:0]
                                   : dur[DURATION_BITS_DEF-1:0];
        seg.last = last;
        segment_q.push_back(seg);
    endfunction

    function automatic void predict_segments(input logic [7:0] code);
        logic [63:0] spd;
        logic [63:0] wx;
        logic [63:0] unit_len;
        logic [63:0] dit_len;
        logic [63:0] dash_len;
        logic [63:0] corr_len;
        logic [63:0] comp_len;
        logic [7:0]  pat;
        spd      = (speed_reg == 7'd0) ? 64'd1 : 64'(speed_reg);
        wx       = (weight_reg < LOW_WEIGHT) ? 64'(LOW_WEIGHT) : 64'(weight_reg);
        unit_len = UNIT_US / spd;
        dit_len  = unit_len * 64'd32 / (wx - 64'(WEIGHT_BASE));
        dash_len = unit_len * 64'd2 * wx / (wx - 64'(WEIGHT_BASE));
        corr_len = CORR_STEP * 64'(corr_reg);
        comp_len = (unit_len > corr_len) ? unit_len - corr_len : unit_len;
        if (code == SPACE_CODE)
        begin
            push_segment(1'b0, 1'b0,
                         (prev_was_space ? 64'd6 : 64'd3) * unit_len + comp_len, 1'b1);
            prev_was_space = 1'b1;
            return;
        end
        prev_was_space = 1'b0;
        pat = NO_PATTERN;
        if (code >= FIRST_CODE && code <= LAST_CODE)
            pat = ELEMENT_PATTERNS[code - FIRST_CODE];
        while (pat > 8'd1)
        begin
            push_segment(1'b1, ptt_reg, pat[0] ? dash_len : dit_len, 1'b0);
            push_segment(1'b0, ptt_reg, unit_len, 1'b0);
            pat = pat >> 1;
        end
        push_segment(1'b0, 1'b0, 64'd2 * unit_len, 1'b1);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (segment_q.size() == 0)
                report_mismatch("unexpected segment", 0, m_tdata);
            else
            begin
                want_seg = segment_q.pop_front();
                if (m_tdata[0] !== want_seg.key)
                    report_mismatch("key_level", want_seg.key, m_tdata[0]);
                if (m_tdata[1] !== want_seg.ptt)
                    report_mismatch("ptt_level", want_seg.ptt, m_tdata[1]);
                if (m_tdata[DURATION_BITS_DEF+1:2] !== want_seg.dur)
                    report_mismatch("duration_us", want_seg.dur, m_tdata[DURATION_BITS_DEF+1:2]);
                if (m_tdata[TDATA_W-1:DURATION_BITS_DEF+2] !== '0)
                    report_mismatch("tdata padding", 0, m_tdata[TDATA_W-1:DURATION_BITS_DEF+2]);
                if (m_tlast !== want_seg.last)
                    report_mismatch("last_segment", want_seg.last, m_tlast);
            end
        end
    end

    // receiver stall pattern: short stalls, short ready runs, occasional long ready runs
    initial
    begin
        int unsigned mode;
        int unsigned len;
        logic        level;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 9);
            if (mode < 3)
            begin
                level = 1'b0;
                len   = $urandom_range(1, 8);
            end
            else if (mode < 9)
            begin
                level = 1'b1;
                len   = $urandom_range(1, 12);
            end
            else
            begin
                level = 1'b1;
                len   = $urandom_range(50, 300);
            end
            @(negedge clk);
            m_tready <= level;
            repeat (len - 1) @(negedge clk);
        end
    end

    // called and returns at a falling edge
    task automatic send_char(input logic [7:0] code);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_segments(code);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_SPEED:  speed_reg  = data[6:0];
            REG_WEIGHT: weight_reg = data[6:0];
            REG_CORR:   corr_reg   = data[9:0];
            REG_PTT:    ptt_reg    = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (segment_q.size() != 0)
            @(posedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_timing(input logic [6:0] spd, input logic [6:0] wgt,
                              input logic [9:0] corr, input logic ptt);
        write_reg(REG_SPEED, CFG_DATA_W'(spd));
        write_reg(REG_WEIGHT, CFG_DATA_W'(wgt));
        write_reg(REG_CORR, corr);
        write_reg(REG_PTT, CFG_DATA_W'(ptt));
    endtask

    task automatic test_default_timing();
        send_char(8'd0);
        send_char(8'd255);
        send_char(8'd31);
        send_char(8'd127);
        send_char(FIRST_CODE);
        send_char(LAST_CODE);
        send_char("$");
        send_char("E");
        send_char("T");
        send_char("0");
        send_char("@");
        wait_idle();
    endtask

    task automatic test_word_gaps();
        send_char(SPACE_CODE);
        send_char(SPACE_CODE);
        send_char(SPACE_CODE);
        send_char("A");
        send_char(SPACE_CODE);
        wait_idle();
    endtask

    task automatic test_register_extremes();
        // zero speed, lowest weight, largest correction, PTT on
        set_timing(7'd0, LOW_WEIGHT, 10'd1023, 1'b1);
        write_reg(REG_UNUSED, 10'h3FF);
        send_char("0");
        send_char(SPACE_CODE);
        send_char(SPACE_CODE);
        wait_idle();
        set_timing(7'd127, 7'd127, 10'd0, 1'b0);
        send_char("0");
        send_char(SPACE_CODE);
        send_char(SPACE_CODE);
        wait_idle();
        // weight below range clamps; correction exceeds the unit
        set_timing(7'd99, 7'd0, 10'd1000, 1'b1);
        send_char("0");
        send_char(SPACE_CODE);
        send_char(SPACE_CODE);
        wait_idle();
    endtask

    task automatic test_random_traffic();
        logic [6:0]  spd;
        logic [6:0]  wgt;
        int unsigned pick;
        for (int phase = 0; phase < 5; phase++)
        begin
            spd = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(5, 99));
            wgt = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(17, 96));
            set_timing(spd, wgt, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
            for (int n = 0; n < 25; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_char(8'($urandom_range(FIRST_CODE, LAST_CODE)));
                else if (pick < 85)
                    send_char(SPACE_CODE);
                else
                    send_char(8'($urandom_range(0, 255)));
            end
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_default_timing();
        test_word_gaps();
        test_register_extremes();
        test_random_traffic();
        while (segment_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && segment_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
